// ----- rtl/hm1511_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hm1511_pkg: shared types and constants of the Hamming (15,11) stream decoder
// Widths of the codeword, data word and counters, and the structs that travel
// between the word decoder and the top level.
// ----------------------------------------------------------------------------
package hm1511_pkg;

  localparam int CODE_BITS = 15;
  localparam int DATA_BITS = 11;
  localparam int SYN_BITS  = 4;
  localparam int BYTE_BITS = 8;
  localparam int CNT_BITS  = 32;

  // One decoded codeword.
  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic                 corrected;
  } dec_res_t;

  // Result bytes caused by one input beat, with the counters after it.
  typedef struct packed {
    logic [1:0]           cnt;
    logic [BYTE_BITS-1:0] b0;
    logic [BYTE_BITS-1:0] b1;
    logic [CNT_BITS-1:0]  bytes;
    logic [CNT_BITS-1:0]  corr;
  } res_grp_t;

endpackage

// ----- rtl/hm1511_word_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hm1511_word_dec: single codeword decoder
// Computes the syndrome of one 15-bit codeword, corrects a data bit it points
// at, and extracts the 11 data bits.
// ----------------------------------------------------------------------------
module hm1511_word_dec (
  input  logic [hm1511_pkg::CODE_BITS-1:0] code_word,
  output hm1511_pkg::dec_res_t             dec_res
);
  import hm1511_pkg::*;

  logic [SYN_BITS-1:0]  syn;
  logic                 fix;
  logic [CODE_BITS-1:0] fixed_word;

  // The syndrome is the XOR of the positions of all set bits.
  always_comb begin
    syn = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (code_word[p-1]) begin
        syn = syn ^ SYN_BITS'(p);
      end
    end
  end

  // Only a syndrome naming a data position (not zero, not a power of two)
  // is corrected; one naming a parity bit is ignored.
  assign fix = (syn != '0) && ((syn & (syn - SYN_BITS'(1))) != '0);

  always_comb begin
    fixed_word = code_word;
    if (fix) begin
      fixed_word = code_word ^ (CODE_BITS'(1) << (syn - SYN_BITS'(1)));
    end
  end

  // Data positions 3, 5, 6, 7 and 9 through 15.
  assign dec_res.data = {fixed_word[14:8], fixed_word[6:4], fixed_word[2]};
  assign dec_res.corrected = fix;

endmodule

// ----- rtl/hamming_15_11_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_15_11_stream_decoder_top: Hamming (15,11) byte stream decoder
// Repacks received bytes LSB first into 15-bit codewords, corrects single
// data-bit errors, and repacks the 11 data bits per word into output bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata                                  | tlast
//  --------+-----------+----------------------------------------+-------------
//  in_     | slave     | [7:0] rx_byte                          | datagram_end
//  out_    | master    | [7:0] out_byte, [39:8] bytes_received, | run_last
//          |           | [71:40] corrected_words                |
//
// Each accepted beat is decoded in the cycle it is accepted: the bit
// accumulators and counters update at that edge and the zero, one or two
// result bytes it causes are written into a result register at the same
// edge. The result side holds two groups (head and tail); each group
// carries all results of one input beat. in_tready is low only while the
// tail is full. With the output always ready the tail fills only when a
// beat with results arrives right behind a two-byte group, and the input
// then pauses. A beat that yields two bytes leaves as two output beats.
// Reset clears the accumulators, counters and both result groups.
// ----------------------------------------------------------------------------
module hamming_15_11_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // datagram_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] out_byte, [39:8] bytes_received,
                                  // [71:40] corrected_words
  output logic        out_tlast   // run_last
);
  import hm1511_pkg::*;

  // Input accumulator holds fewer than 15 bits between beats, the output
  // accumulator fewer than 8.
  logic [CODE_BITS-2:0] in_bits_r,  in_bits_nxt;
  logic [3:0]           in_cnt_r,   in_cnt_nxt;
  logic [BYTE_BITS-2:0] out_bits_r, out_bits_nxt;
  logic [2:0]           out_cnt_r,  out_cnt_nxt;
  logic [CNT_BITS-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [CNT_BITS-1:0]  corr_cnt_r, corr_cnt_nxt;
  res_grp_t             head_r, head_nxt;
  res_grp_t             tail_r, tail_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic [21:0]          in_cat;
  logic [4:0]           in_sum;
  logic                 have_word;
  dec_res_t             dec_res;
  logic [17:0]          out_cat;
  logic [4:0]           out_sum;
  logic [1:0]           n_res;
  res_grp_t             new_grp;

  hm1511_word_dec u_word_dec (
    .code_word (in_cat[CODE_BITS-1:0]),
    .dec_res   (dec_res)
  );

  assign in_tready  = (tail_r.cnt == 2'd0);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (head_r.cnt != 2'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {head_r.corr, head_r.bytes, head_r.b0};
  assign out_tlast  = (head_r.cnt == 2'd1);

  // Append the new byte above the bits already held, then take a codeword
  // off the bottom once 15 bits are present.
  always_comb begin
    in_cat    = 22'(in_bits_r) | (22'(in_tdata) << in_cnt_r);
    in_sum    = 5'(in_cnt_r) + 5'd8;
    have_word = (in_sum >= 5'(CODE_BITS));

    out_cat = 18'(out_bits_r);
    out_sum = 5'(out_cnt_r);
    if (have_word) begin
      out_cat = out_cat | (18'(dec_res.data) << out_cnt_r);
      out_sum = out_sum + 5'(DATA_BITS);
    end

    if (out_sum >= 5'd16) begin
      n_res = 2'd2;
    end else if (out_sum >= 5'd8) begin
      n_res = 2'd1;
    end else begin
      n_res = 2'd0;
    end

    byte_cnt_nxt = byte_cnt_r;
    corr_cnt_nxt = corr_cnt_r;
    in_bits_nxt  = in_bits_r;
    in_cnt_nxt   = in_cnt_r;
    out_bits_nxt = out_bits_r;
    out_cnt_nxt  = out_cnt_r;

    if (in_acc) begin
      byte_cnt_nxt = byte_cnt_r + CNT_BITS'(1);
      if (have_word && dec_res.corrected) begin
        corr_cnt_nxt = corr_cnt_r + CNT_BITS'(1);
      end
      if (have_word) begin
        // At most seven bits remain above the codeword.
        in_bits_nxt = {7'd0, in_cat[21:CODE_BITS]};
        in_cnt_nxt  = 4'(in_sum - 5'(CODE_BITS));
      end else begin
        in_bits_nxt = in_cat[CODE_BITS-2:0];
        in_cnt_nxt  = in_sum[3:0];
      end
      // At most two bytes leave; the remainder is always below eight bits.
      case (n_res)
        2'd2:    out_bits_nxt = {5'd0, out_cat[17:16]};
        2'd1:    out_bits_nxt = out_cat[8 +: BYTE_BITS-1];
        default: out_bits_nxt = out_cat[BYTE_BITS-2:0];
      endcase
      out_cnt_nxt = out_sum[2:0];
      // A datagram end drops the leftover bits and realigns.
      if (in_tlast) begin
        in_bits_nxt  = '0;
        in_cnt_nxt   = '0;
        out_bits_nxt = '0;
        out_cnt_nxt  = '0;
      end
    end

    new_grp.cnt   = n_res;
    new_grp.b0    = out_cat[7:0];
    new_grp.b1    = out_cat[15:8];
    new_grp.bytes = byte_cnt_nxt;
    new_grp.corr  = corr_cnt_nxt;
  end

  // Result groups: the head drains one byte per handshake, the tail moves
  // up when the head empties, and a new group goes to the first free slot.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (out_acc) begin
      head_nxt.cnt = head_r.cnt - 2'd1;
      head_nxt.b0  = head_r.b1;
    end
    if (head_nxt.cnt == 2'd0 && tail_r.cnt != 2'd0) begin
      head_nxt     = tail_r;
      tail_nxt.cnt = 2'd0;
    end
    if (in_acc && n_res != 2'd0) begin
      if (head_nxt.cnt == 2'd0) begin
        head_nxt = new_grp;
      end else begin
        tail_nxt = new_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r  <= '0;
      in_cnt_r   <= '0;
      out_bits_r <= '0;
      out_cnt_r  <= '0;
      byte_cnt_r <= '0;
      corr_cnt_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
    end else begin
      in_bits_r  <= in_bits_nxt;
      in_cnt_r   <= in_cnt_nxt;
      out_bits_r <= out_bits_nxt;
      out_cnt_r  <= out_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      corr_cnt_r <= corr_cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
    end
  end

`ifndef SYNTHESIS
  // The tail only fills behind a busy head.
  a_tail_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r.cnt != 2'd0) |-> (head_r.cnt != 2'd0))
    else $error("result tail holds a group while head is empty");

  // A group never holds more than two bytes.
  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r.cnt != 2'd3) && (tail_r.cnt != 2'd3))
    else $error("result group count out of range");

  // A datagram end realigns both accumulators.
  a_realign: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (in_cnt_r == 4'd0) && (out_cnt_r == 3'd0))
    else $error("alignment not reset after datagram end");

  // The byte counter advances by one on every accepted beat.
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (byte_cnt_r == $past(byte_cnt_r) + CNT_BITS'(1)))
    else $error("byte counter did not advance on accepted beat");

  // The input accumulator never keeps a whole codeword.
  a_in_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_cnt_r < 4'(CODE_BITS))
    else $error("input accumulator holds a full codeword");
`endif

endmodule

// ----- sim/hamming_15_11_stream_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_15_11_stream_decoder_top_test: self-checking bench for the decoder
// Feeds channel bytes through the input stream, predicts every decoded data
// byte and the running counters, and checks each output beat against the
// oldest prediction. Both stream sides idle at random, with a quiet stretch
// and a long output stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module hamming_15_11_stream_decoder_top_test;
  import hm1511_pkg::*;

  // One directed stimulus row. Rows marked as typed carry a hand-written
  // expectation (at most one output byte); all other rows rely on the
  // predictor alone.
  typedef struct packed {
    logic [7:0]  rx;
    logic        dend;
    logic        typed;
    logic        has_byte;
    logic [7:0]  want_byte;
    logic [31:0] want_count;
    logic [31:0] want_fixes;
  } stim_row_t;

  // One predicted output beat.
  typedef struct {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 run_last;
    logic [CNT_BITS-1:0]  bytes_seen;
    logic [CNT_BITS-1:0]  fixes;
  } decoded_byte_t;

  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 650;

  // Directed part. The first rows start from reset and end every codeword
  // with a datagram end so the expected bytes can be worked out by hand:
  // all-zero word, all-ones word, a flipped data bit at position 3 and a
  // flipped parity bit at position 1. Later rows cover the top data bit,
  // a parity hit at position 8, a datagram end with leftover bits and a
  // long run that yields two bytes from one beat.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 32'd2, 32'd0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 32'd4, 32'd0},
    '{8'h04, 1'b0, 1'b1, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 32'd6, 32'd1},
    '{8'h01, 1'b0, 1'b1, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 32'd8, 32'd1},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h40, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'hA5, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h7E, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h96, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h69, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h12, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'hED, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0},
    '{8'h81, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  // Predictor state: bit accumulators on both sides and the running counters.
  logic [21:0]         code_acc;
  int                  code_fill;
  logic [17:0]         data_acc;
  int                  data_fill;
  logic [CNT_BITS-1:0] beat_total;
  logic [CNT_BITS-1:0] fix_total;

  decoded_byte_t pending_bytes[$];
  decoded_byte_t want_byte;
  int            mismatch_count = 0;

  // Shared between the sender and the receiver: a quiet stretch where
  // neither side idles, and a request for one long output stall.
  bit calm_stretch = 1'b0;
  bit stall_req    = 1'b0;
  int stall_left   = 0;

  hamming_15_11_stream_decoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Fixes one 15-bit codeword (position p held in bit p-1) and pulls out
  // its 11 data bits. A syndrome that lands on a parity position leaves the
  // word alone.
  function automatic void fix_codeword(input logic [CODE_BITS-1:0] cw_in,
                                       output logic [DATA_BITS-1:0] data,
                                       output bit fixed);
    logic [CODE_BITS-1:0] cw;
    logic [SYN_BITS-1:0]  syn;
    int                   n;
    cw    = cw_in;
    syn   = '0;
    data  = '0;
    n     = 0;
    fixed = 1'b0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (cw[p-1]) syn ^= SYN_BITS'(p);
    end
    if (syn != 0 && (syn & (syn - 1'b1)) != 0) begin
      cw[syn-1] = ~cw[syn-1];
      fixed     = 1'b1;
    end
    for (int p = 1; p <= CODE_BITS; p++) begin
      if ((p & (p - 1)) != 0) begin
        data[n] = cw[p-1];
        n++;
      end
    end
  endfunction

  // Advances the predictor by one accepted input beat. When keep is set the
  // bytes it yields are queued as expected output beats.
  task automatic decode_beat(input logic [7:0] rx, input logic dend, input bit keep);
    logic [DATA_BITS-1:0] data;
    bit                   fixed;
    logic [7:0]           done_b [2];
    int                   n_done;
    decoded_byte_t        item;
    beat_total++;
    code_acc  = code_acc | (22'(rx) << code_fill);
    code_fill = code_fill + 8;
    if (code_fill >= CODE_BITS) begin
      fix_codeword(code_acc[CODE_BITS-1:0], data, fixed);
      if (fixed) fix_total++;
      code_acc  = code_acc >> CODE_BITS;
      code_fill = code_fill - CODE_BITS;
      data_acc  = data_acc | (18'(data) << data_fill);
      data_fill = data_fill + DATA_BITS;
    end
    n_done = 0;
    while (data_fill >= 8 && n_done < 2) begin
      done_b[n_done] = data_acc[7:0];
      n_done++;
      data_acc  = data_acc >> 8;
      data_fill = data_fill - 8;
    end
    if (dend) begin
      code_acc  = '0;
      code_fill = 0;
      data_acc  = '0;
      data_fill = 0;
    end
    if (keep) begin
      for (int k = 0; k < n_done; k++) begin
        item.data_byte  = done_b[k];
        item.run_last   = (k == n_done - 1);
        item.bytes_seen = beat_total;
        item.fixes      = fix_total;
        pending_bytes.push_back(item);
      end
    end
  endtask

  // Offers one beat at a falling edge, with random idle cycles ahead of it,
  // and holds it until the block takes it. Returns at the next falling edge.
  task automatic offer_beat(input stim_row_t row);
    decoded_byte_t item;
    while (!calm_stretch && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.rx;
    in_tlast  <= row.dend;
    do @(posedge clk); while (!in_tready);
    decode_beat(row.rx, row.dend, !row.typed);
    if (row.typed && row.has_byte) begin
      item.data_byte  = row.want_byte;
      item.run_last   = 1'b1;
      item.bytes_seen = row.want_count;
      item.fixes      = row.want_fixes;
      pending_bytes.push_back(item);
    end
    @(negedge clk);
  endtask

  function automatic void note_mismatch(input string what);
    if (mismatch_count < 10) $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endfunction

  // Sender: reset, the directed table, then random datagrams. Datagram
  // lengths vary from one byte up to several codewords, so the end marker
  // lands on every bit alignment.
  initial begin
    stim_row_t row;
    int        left_in_dgram;
    code_acc   = '0;
    code_fill  = 0;
    data_acc   = '0;
    data_fill  = 0;
    beat_total = '0;
    fix_total  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_beat(DIRECTED_ROWS[i]);
    end

    left_in_dgram = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Ask for the long output stall at the sixth random beat while beats keep coming.
      if (i == 5) stall_req = 1'b1;
      calm_stretch = (i >= 300 && i < 420);
      if (left_in_dgram == 0) left_in_dgram = $urandom_range(40, 1);
      row          = '0;
      row.rx       = 8'($urandom_range(255));
      row.dend     = (left_in_dgram == 1);
      left_in_dgram--;
      offer_beat(row);
    end
    calm_stretch = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random back-pressure, none during the quiet stretch, and one
  // long stall that fills the result groups and pushes back on the input.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_left = 90;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (calm_stretch) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 38);
      end
    end
  end

  // Output checker: every accepted beat is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: tdata=%h tlast=%b",
                                out_tdata, out_tlast));
      end else begin
        want_byte = pending_bytes.pop_front();
        if (out_tdata[7:0] !== want_byte.data_byte ||
            out_tlast !== want_byte.run_last ||
            out_tdata[39:8] !== want_byte.bytes_seen ||
            out_tdata[71:40] !== want_byte.fixes) begin
          note_mismatch($sformatf(
            "expected byte=%h last=%b count=%0d fixes=%0d, got byte=%h last=%b count=%0d fixes=%0d",
            want_byte.data_byte, want_byte.run_last, want_byte.bytes_seen, want_byte.fixes,
            out_tdata[7:0], out_tlast, out_tdata[39:8], out_tdata[71:40]));
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
